// ----- rtl/ned2enu_pkg.sv -----
// shared widths, branch codes and control struct for the ned to enu pose pipeline
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
package ned2enu_pkg;

  // quaternion word and fraction
  localparam int QW     = 32;
  localparam int QFB    = 30;
  // floored product, matrix entry, radicand and numerator widths
  localparam int PROD_W = 34;
  localparam int MAT_W  = 38;
  localparam int RAD_W  = 36;
  localparam int NUM_W  = 38;
  localparam int MAG_W  = 37;
  // square root: radicand shifted by QFB gives 33 bit pairs
  localparam int SQ_PAIRS = (RAD_W + QFB) / 2;
  localparam int ROOT_W   = SQ_PAIRS;
  // divisor is twice the root
  localparam int DIV_W    = ROOT_W + 1;

  localparam logic signed [QW-1:0] QMAX = {1'b0, {(QW-1){1'b1}}};
  localparam logic signed [QW-1:0] QMIN = {1'b1, {(QW-1){1'b0}}};

  // trace-method branch: which output slot holds the diagonal term
  localparam logic [1:0] BR_W = 2'd0;
  localparam logic [1:0] BR_X = 2'd1;
  localparam logic [1:0] BR_Y = 2'd2;
  localparam logic [1:0] BR_Z = 2'd3;

  typedef struct packed {
    logic [1:0] br;
    logic       deg;
  } sel_t;

endpackage

// ----- rtl/ned2enu_front.sv -----
// front end: quaternion products, rotation matrix, branch choice and radicand
// depends on ned2enu_pkg; three register stages
`timescale 1ns / 1ps
module ned2enu_front import ned2enu_pkg::*; #(
  parameter int SIDE_W = 96
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic [SIDE_W-1:0]       side_in,
  input  logic signed [QW-1:0]    q_w_in,
  input  logic signed [QW-1:0]    q_x_in,
  input  logic signed [QW-1:0]    q_y_in,
  input  logic signed [QW-1:0]    q_z_in,
  output logic                    out_valid,
  output logic [SIDE_W-1:0]       side_out,
  output sel_t                    sel_out,
  output logic [RAD_W-1:0]        rad_out,
  output logic signed [NUM_W-1:0] a_out,
  output logic signed [NUM_W-1:0] b_out,
  output logic signed [NUM_W-1:0] c_out
);

  localparam logic signed [MAT_W-1:0] ONE = MAT_W'(1) <<< QFB;

  // full products
  logic signed [2*QW-1:0] m_xx, m_yy, m_zz, m_wx, m_wy, m_wz, m_xy, m_xz, m_yz;
  assign m_xx = q_x_in * q_x_in;
  assign m_yy = q_y_in * q_y_in;
  assign m_zz = q_z_in * q_z_in;
  assign m_wx = q_w_in * q_x_in;
  assign m_wy = q_w_in * q_y_in;
  assign m_wz = q_w_in * q_z_in;
  assign m_xy = q_x_in * q_y_in;
  assign m_xz = q_x_in * q_z_in;
  assign m_yz = q_y_in * q_z_in;

  // stage 1: products floored to Q.30
  logic                     v1;
  logic [SIDE_W-1:0]        sd1;
  logic signed [PROD_W-1:0] p_xx, p_yy, p_zz, p_wx, p_wy, p_wz, p_xy, p_xz, p_yz;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd1  <= side_in;
      p_xx <= m_xx[QFB +: PROD_W];
      p_yy <= m_yy[QFB +: PROD_W];
      p_zz <= m_zz[QFB +: PROD_W];
      p_wx <= m_wx[QFB +: PROD_W];
      p_wy <= m_wy[QFB +: PROD_W];
      p_wz <= m_wz[QFB +: PROD_W];
      p_xy <= m_xy[QFB +: PROD_W];
      p_xz <= m_xz[QFB +: PROD_W];
      p_yz <= m_yz[QFB +: PROD_W];
    end
  end

  logic signed [MAT_W-1:0] e_xx, e_yy, e_zz, e_wx, e_wy, e_wz, e_xy, e_xz, e_yz;
  assign e_xx = MAT_W'(p_xx);
  assign e_yy = MAT_W'(p_yy);
  assign e_zz = MAT_W'(p_zz);
  assign e_wx = MAT_W'(p_wx);
  assign e_wy = MAT_W'(p_wy);
  assign e_wz = MAT_W'(p_wz);
  assign e_xy = MAT_W'(p_xy);
  assign e_xz = MAT_W'(p_xz);
  assign e_yz = MAT_W'(p_yz);

  // stage 2: rotation matrix entries
  logic                    v2;
  logic [SIDE_W-1:0]       sd2;
  logic signed [MAT_W-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd2 <= sd1;
      r00 <= ONE - ((e_yy + e_zz) <<< 1);
      r01 <= (e_xy - e_wz) <<< 1;
      r02 <= (e_xz + e_wy) <<< 1;
      r10 <= (e_xy + e_wz) <<< 1;
      r11 <= ONE - ((e_xx + e_zz) <<< 1);
      r12 <= (e_yz - e_wx) <<< 1;
      r20 <= (e_xz - e_wy) <<< 1;
      r21 <= (e_yz + e_wx) <<< 1;
      r22 <= ONE - ((e_xx + e_yy) <<< 1);
    end
  end

  // enu matrix after both permutations: e00=r10, e11=-r01, e22=r22
  logic signed [MAT_W-1:0] tr, rad;
  logic signed [NUM_W-1:0] na, nb, nc;
  logic [1:0]              br;

  always_comb begin
    tr = r10 - r01 + r22;
    if (tr > 0) begin
      br  = BR_W;
      rad = tr + ONE;
      na  = r21 + r02;
      nb  = r20 - r12;
      nc  = r00 + r11;
    end else if ((r10 > -r01) && (r10 > r22)) begin
      br  = BR_X;
      rad = ONE + r10 + r01 - r22;
      na  = r21 + r02;
      nb  = r00 - r11;
      nc  = -r12 - r20;
    end else if (-r01 > r22) begin
      br  = BR_Y;
      rad = ONE - r01 - r10 - r22;
      na  = r20 - r12;
      nb  = r00 - r11;
      nc  = r21 - r02;
    end else begin
      br  = BR_Z;
      rad = ONE + r22 - r10 + r01;
      na  = r00 + r11;
      nb  = -r12 - r20;
      nc  = r21 - r02;
    end
  end

  // stage 3: branch, radicand and numerators
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= v2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_out    <= sd2;
      sel_out.br  <= br;
      sel_out.deg <= rad[MAT_W-1] || (rad == '0);
      rad_out     <= rad[RAD_W-1:0];
      a_out       <= na;
      b_out       <= nb;
      c_out       <= nc;
    end
  end

endmodule

// ----- rtl/ned2enu_sqrt.sv -----
// pipelined square root, one root bit per stage: floor(sqrt(rad * 2^30))
// depends on ned2enu_pkg
`timescale 1ns / 1ps
module ned2enu_sqrt import ned2enu_pkg::*; #(
  parameter int SIDE_W = 96
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic [SIDE_W-1:0]  side_in,
  input  logic [RAD_W-1:0]   rad_in,
  output logic               out_valid,
  output logic [SIDE_W-1:0]  side_out,
  output logic [ROOT_W-1:0]  root_out
);

  localparam int XW = RAD_W + QFB;

  logic              v  [0:SQ_PAIRS];
  logic [SIDE_W-1:0] sd [0:SQ_PAIRS];
  logic [RAD_W-1:0]  xr [0:SQ_PAIRS];
  logic [ROOT_W+1:0] rm [0:SQ_PAIRS];
  logic [ROOT_W-1:0] rt [0:SQ_PAIRS];

  assign v[0]  = in_valid;
  assign sd[0] = side_in;
  assign xr[0] = rad_in;
  assign rm[0] = '0;
  assign rt[0] = '0;

  // one digit pair per stage, most significant first
  for (genvar s = 0; s < SQ_PAIRS; s++) begin : g_stage
    localparam int K = SQ_PAIRS - 1 - s;
    logic [XW-1:0]     xs;
    logic [ROOT_W+3:0] rem2, trial, diff;
    logic              ge;

    assign xs    = {xr[s], {QFB{1'b0}}};
    assign rem2  = {rm[s], xs[2*K +: 2]};
    assign trial = {2'b00, rt[s], 2'b01};
    assign ge    = rem2 >= trial;
    assign diff  = rem2 - trial;

    always_ff @(posedge clk) begin
      if (rst) v[s+1] <= 1'b0;
      else if (en) v[s+1] <= v[s];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sd[s+1] <= sd[s];
        xr[s+1] <= xr[s];
        rm[s+1] <= ge ? diff[ROOT_W+1:0] : rem2[ROOT_W+1:0];
        rt[s+1] <= {rt[s][ROOT_W-2:0], ge};
      end
    end
  end

  assign out_valid = v[SQ_PAIRS];
  assign side_out  = sd[SQ_PAIRS];
  assign root_out  = rt[SQ_PAIRS];

endmodule

// ----- rtl/ned2enu_div.sv -----
// three-lane pipelined divider: n * 2^30 / (2 * root), truncated and saturated
// depends on ned2enu_pkg; one quotient bit per stage, lanes share the divisor
`timescale 1ns / 1ps
module ned2enu_div import ned2enu_pkg::*; #(
  parameter int SIDE_W = 96
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic [SIDE_W-1:0]       side_in,
  input  logic [ROOT_W-1:0]       root_in,
  input  logic signed [NUM_W-1:0] a_in,
  input  logic signed [NUM_W-1:0] b_in,
  input  logic signed [NUM_W-1:0] c_in,
  output logic                    out_valid,
  output logic [SIDE_W-1:0]       side_out,
  output logic signed [QW-1:0]    qa_out,
  output logic signed [QW-1:0]    qb_out,
  output logic signed [QW-1:0]    qc_out
);

  localparam int NSTEP = QW;

  logic                        v   [0:NSTEP];
  logic [SIDE_W-1:0]           sd  [0:NSTEP];
  logic [DIV_W-1:0]            dv  [0:NSTEP];
  logic [2:0][DIV_W-1:0]       rr  [0:NSTEP];
  logic [2:0][QW-1:0]          qq  [0:NSTEP];
  logic [2:0]                  ng  [0:NSTEP];
  logic [2:0]                  ov  [0:NSTEP];
  logic [2:0][1:0]             lo  [0:NSTEP];

  // sign, magnitude and overflow check per lane
  logic [2:0][NUM_W-1:0] num;
  logic [2:0][MAG_W-1:0] mag;
  logic [2:0]            neg0, ovf0;
  logic [MAG_W-1:0]      lim;

  assign num[0] = a_in;
  assign num[1] = b_in;
  assign num[2] = c_in;
  assign lim    = MAG_W'({root_in, 3'b000});

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      neg0[l] = num[l][NUM_W-1];
      mag[l]  = neg0[l] ? MAG_W'(-num[l]) : MAG_W'(num[l]);
      ovf0[l] = mag[l] >= lim;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v[0] <= 1'b0;
    else if (en) v[0] <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd[0] <= side_in;
      dv[0] <= {root_in, 1'b0};
      for (int l = 0; l < 3; l++) begin
        rr[0][l] <= mag[l][DIV_W+1:2];
        qq[0][l] <= '0;
        lo[0][l] <= mag[l][1:0];
      end
      ng[0] <= neg0;
      ov[0] <= ovf0;
    end
  end

  // long division steps; the two low magnitude bits feed the first two steps
  for (genvar i = 0; i < NSTEP; i++) begin : g_step
    logic [2:0][DIV_W:0] r2, df;
    logic [2:0]          ge;

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        if (i == 0) r2[l] = {rr[i][l], lo[i][l][1]};
        else if (i == 1) r2[l] = {rr[i][l], lo[i][l][0]};
        else r2[l] = {rr[i][l], 1'b0};
        ge[l] = r2[l] >= {1'b0, dv[i]};
        df[l] = r2[l] - {1'b0, dv[i]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) v[i+1] <= 1'b0;
      else if (en) v[i+1] <= v[i];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sd[i+1] <= sd[i];
        dv[i+1] <= dv[i];
        ng[i+1] <= ng[i];
        ov[i+1] <= ov[i];
        lo[i+1] <= lo[i];
        for (int l = 0; l < 3; l++) begin
          rr[i+1][l] <= ge[l] ? df[l][DIV_W-1:0] : r2[l][DIV_W-1:0];
          qq[i+1][l] <= {qq[i][l][QW-2:0], ge[l]};
        end
      end
    end
  end

  // sign and saturation
  logic [2:0][QW-1:0] res;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (ov[NSTEP][l] || qq[NSTEP][l][QW-1]) res[l] = ng[NSTEP][l] ? QMIN : QMAX;
      else res[l] = ng[NSTEP][l] ? -qq[NSTEP][l] : qq[NSTEP][l];
    end
  end

  assign out_valid = v[NSTEP];
  assign side_out  = sd[NSTEP];
  assign qa_out    = res[0];
  assign qb_out    = res[1];
  assign qc_out    = res[2];

endmodule

// ----- rtl/ned_to_enu_pose_conversion_core.sv -----
// top level of the ned to enu pose converter: position reorder, attitude pipeline
// depends on ned2enu_pkg, ned2enu_front, ned2enu_sqrt, ned2enu_div
`timescale 1ns / 1ps
// Converts one NED pose per transaction to ENU: east/north are passed through, up is
// the negated down value saturated at the positive limit, and the attitude quaternion
// goes through rotation matrix, axis permutation and the four-branch trace method.
// A new pose is accepted every clock cycle unless the pipeline stalls; each pose passes
// through 3 front-end stages (products, matrix, branch), 33 square-root stages (one
// root bit each), 33 divider stages (overflow check plus one quotient bit each) and
// the output register. The whole pipeline advances together, so it stalls only when
// a finished result sits in the output register and is not taken. When the radicand
// is not positive, degenerate is set and the quaternion outputs are zero.
module ned_to_enu_pose_conversion_core import ned2enu_pkg::*; #(
  parameter int POS_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [POS_WIDTH-1:0] north_in,
  input  logic signed [POS_WIDTH-1:0] east_in,
  input  logic signed [POS_WIDTH-1:0] down_in,
  input  logic signed [QW-1:0]        q_w_in,
  input  logic signed [QW-1:0]        q_x_in,
  input  logic signed [QW-1:0]        q_y_in,
  input  logic signed [QW-1:0]        q_z_in,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [POS_WIDTH-1:0] east_out,
  output logic signed [POS_WIDTH-1:0] north_out,
  output logic signed [POS_WIDTH-1:0] up_out,
  output logic signed [QW-1:0]        q_w_out,
  output logic signed [QW-1:0]        q_x_out,
  output logic signed [QW-1:0]        q_y_out,
  output logic signed [QW-1:0]        q_z_out,
  output logic                        degenerate
);

  localparam int POS3    = 3 * POS_WIDTH;
  localparam int SQ_SIDE = POS3 + $bits(sel_t) + 3 * NUM_W;
  localparam int DV_SIDE = POS3 + $bits(sel_t) + ROOT_W;
  localparam logic signed [POS_WIDTH-1:0] PMIN = {1'b1, {(POS_WIDTH-1){1'b0}}};
  localparam logic signed [POS_WIDTH-1:0] PMAX = {1'b0, {(POS_WIDTH-1){1'b1}}};

  // global advance: move unless a result is waiting
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // position: reorder and negate down
  logic signed [POS_WIDTH-1:0] up;
  logic [POS3-1:0]             pos_in;
  assign up     = (down_in == PMIN) ? PMAX : -down_in;
  assign pos_in = {east_in, north_in, up};

  // front end
  logic                    fr_valid;
  logic [POS3-1:0]         fr_pos;
  sel_t                    fr_sel;
  logic [RAD_W-1:0]        fr_rad;
  logic signed [NUM_W-1:0] fr_a, fr_b, fr_c;

  ned2enu_front #(.SIDE_W(POS3)) u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .side_in   (pos_in),
    .q_w_in    (q_w_in),
    .q_x_in    (q_x_in),
    .q_y_in    (q_y_in),
    .q_z_in    (q_z_in),
    .out_valid (fr_valid),
    .side_out  (fr_pos),
    .sel_out   (fr_sel),
    .rad_out   (fr_rad),
    .a_out     (fr_a),
    .b_out     (fr_b),
    .c_out     (fr_c)
  );

  // square root
  logic               sq_valid;
  logic [SQ_SIDE-1:0] sq_side;
  logic [ROOT_W-1:0]  sq_root;

  ned2enu_sqrt #(.SIDE_W(SQ_SIDE)) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (fr_valid),
    .side_in   ({fr_pos, fr_sel, fr_a, fr_b, fr_c}),
    .rad_in    (fr_rad),
    .out_valid (sq_valid),
    .side_out  (sq_side),
    .root_out  (sq_root)
  );

  logic [POS3-1:0]         sq_pos;
  sel_t                    sq_sel;
  logic signed [NUM_W-1:0] sq_a, sq_b, sq_c;
  assign {sq_pos, sq_sel, sq_a, sq_b, sq_c} = sq_side;

  // dividers
  logic                 dv_valid;
  logic [DV_SIDE-1:0]   dv_side;
  logic signed [QW-1:0] qa, qb, qc;

  ned2enu_div #(.SIDE_W(DV_SIDE)) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sq_valid),
    .side_in   ({sq_pos, sq_sel, sq_root}),
    .root_in   (sq_root),
    .a_in      (sq_a),
    .b_in      (sq_b),
    .c_in      (sq_c),
    .out_valid (dv_valid),
    .side_out  (dv_side),
    .qa_out    (qa),
    .qb_out    (qb),
    .qc_out    (qc)
  );

  logic [POS3-1:0]   dv_pos;
  sel_t              dv_sel;
  logic [ROOT_W-1:0] dv_root;
  assign {dv_pos, dv_sel, dv_root} = dv_side;

  // diagonal term and slot placement
  logic [QW-1:0]        half;
  logic signed [QW-1:0] qd;
  logic signed [QW-1:0] w_next, x_next, y_next, z_next;

  assign half = dv_root[ROOT_W-1:1];
  assign qd   = half[QW-1] ? QMAX : half;

  always_comb begin
    case (dv_sel.br)
      BR_W: begin
        w_next = qd; x_next = qa; y_next = qb; z_next = qc;
      end
      BR_X: begin
        w_next = qa; x_next = qd; y_next = qb; z_next = qc;
      end
      BR_Y: begin
        w_next = qa; x_next = qb; y_next = qd; z_next = qc;
      end
      default: begin
        w_next = qa; x_next = qb; y_next = qc; z_next = qd;
      end
    endcase
    if (dv_sel.deg) begin
      w_next = '0; x_next = '0; y_next = '0; z_next = '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= dv_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      {east_out, north_out, up_out} <= dv_pos;
      q_w_out    <= w_next;
      q_x_out    <= x_next;
      q_y_out    <= y_next;
      q_z_out    <= z_next;
      degenerate <= dv_sel.deg;
    end
  end

  // degenerate poses carry an all-zero quaternion
  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |->
      q_w_out == '0 && q_x_out == '0 && q_y_out == '0 && q_z_out == '0)
    else $error("degenerate pose with nonzero quaternion");

  // a regular pose always has a nonzero diagonal term
  a_nondeg_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !degenerate |->
      !(q_w_out == '0 && q_x_out == '0 && q_y_out == '0 && q_z_out == '0))
    else $error("regular pose with all-zero quaternion");

  // up saturates, never reaching the most negative value
  a_up_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> up_out != PMIN)
    else $error("up position not saturated");

endmodule

// ----- tb/ned_to_enu_pose_conversion_core_tb.sv -----
// self-checking testbench for ned_to_enu_pose_conversion_core
// depends on ned2enu_pkg and the rtl of the block; carries its own pose predictor
`timescale 1ns / 1ps
module ned_to_enu_pose_conversion_core_tb;
  import ned2enu_pkg::*;

  localparam int PW        = 32;
  localparam int WATCHDOG  = 3000;
  localparam int LONG_HOLD = 250;

  typedef struct packed {
    logic signed [PW-1:0] north, east, down;
    logic signed [QW-1:0] qw, qx, qy, qz;
  } ned_pose_t;

  typedef struct packed {
    logic signed [PW-1:0] east, north, up;
    logic signed [QW-1:0] qw, qx, qy, qz;
    logic                 deg;
  } enu_pose_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [PW-1:0] north_in = '0, east_in = '0, down_in = '0;
  logic signed [QW-1:0] q_w_in = '0, q_x_in = '0, q_y_in = '0, q_z_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [PW-1:0] east_out, north_out, up_out;
  logic signed [QW-1:0] q_w_out, q_x_out, q_y_out, q_z_out;
  logic degenerate;

  enu_pose_t enu_expected_q[$];
  int        mismatches = 0;
  int        poses_sent = 0;
  int        poses_checked = 0;
  int        degen_seen = 0;
  int        idle_cycles = 0;
  int        hold_left = 0;
  bit        calm = 1'b0;

  ned_to_enu_pose_conversion_core #(.POS_WIDTH(PW)) u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .north_in(north_in), .east_in(east_in), .down_in(down_in),
    .q_w_in(q_w_in), .q_x_in(q_x_in), .q_y_in(q_y_in), .q_z_in(q_z_in),
    .out_valid(out_valid), .out_ready(out_ready),
    .east_out(east_out), .north_out(north_out), .up_out(up_out),
    .q_w_out(q_w_out), .q_x_out(q_x_out), .q_y_out(q_y_out), .q_z_out(q_z_out),
    .degenerate(degenerate)
  );

  // clock
  initial begin
    forever #6 clk = ~clk;
  end

  // clamp to the signed quaternion word
  function automatic logic [QW-1:0] sat_quat(longint v);
    if (v > longint'(QMAX)) return QMAX;
    if (v < longint'(QMIN)) return QMIN;
    return v[QW-1:0];
  endfunction

  // floor(sqrt(rad * 2^30)), bit by bit
  function automatic longint unsigned root_q30(longint unsigned rad);
    logic [127:0] n, r, t;
    n = {64'd0, rad} << QFB;
    r = '0;
    for (int b = 40; b >= 0; b--) begin
      t = r | (128'd1 << b);
      if (t * t <= n) r = t;
    end
    return r[63:0];
  endfunction

  // num * 2^30 / div, magnitude truncated, capped and saturated
  function automatic logic [QW-1:0] frac_div(longint num, longint unsigned div);
    bit neg;
    longint unsigned mag, q, rem;
    neg = num < 0;
    mag = neg ? longint'(-num) : num;
    q = mag / div;
    rem = mag % div;
    for (int k = 0; k < QFB; k++) begin
      if (q >= (64'd1 << 40)) break;
      q = q << 1;
      rem = rem << 1;
      if (rem >= div) begin
        rem = rem - div;
        q = q | 64'd1;
      end
    end
    if (q > (64'd1 << 40)) q = 64'd1 << 40;
    return sat_quat(neg ? -longint'(q) : longint'(q));
  endfunction

  // expected enu pose for one ned pose
  function automatic enu_pose_t enu_of_ned(ned_pose_t p);
    enu_pose_t o;
    longint w, x, y, z, one, xx, yy, zz, wx, wy, wz, xy, xz, yz;
    longint r[3][3];
    longint e[3][3];
    longint tr, rad, a, b, c;
    longint unsigned root, div;
    logic [1:0] br;
    logic [QW-1:0] qd, qa, qb, qc;
    logic [QW-1:0] slot[4];
    int k;
    w = p.qw; x = p.qx; y = p.qy; z = p.qz;
    one = longint'(1) << QFB;
    xx = (x * x) >>> QFB; yy = (y * y) >>> QFB; zz = (z * z) >>> QFB;
    wx = (w * x) >>> QFB; wy = (w * y) >>> QFB; wz = (w * z) >>> QFB;
    xy = (x * y) >>> QFB; xz = (x * z) >>> QFB; yz = (y * z) >>> QFB;
    r[0][0] = one - 2 * (yy + zz); r[0][1] = 2 * (xy - wz); r[0][2] = 2 * (xz + wy);
    r[1][0] = 2 * (xy + wz); r[1][1] = one - 2 * (xx + zz); r[1][2] = 2 * (yz - wx);
    r[2][0] = 2 * (xz - wy); r[2][1] = 2 * (yz + wx); r[2][2] = one - 2 * (xx + yy);
    // body flip negates columns 1 and 2, world swap exchanges rows 0/1 and negates row 2
    for (int j = 0; j < 3; j++) begin
      e[0][j] = (j == 0) ? r[1][j] : -r[1][j];
      e[1][j] = (j == 0) ? r[0][j] : -r[0][j];
      e[2][j] = (j == 0) ? -r[2][j] : r[2][j];
    end
    o.east  = p.east;
    o.north = p.north;
    o.up    = (p.down == {1'b1, {(PW-1){1'b0}}}) ? {1'b0, {(PW-1){1'b1}}} : -p.down;
    tr = e[0][0] + e[1][1] + e[2][2];
    if (tr > 0) begin
      br = BR_W; rad = tr + one;
      a = e[2][1] - e[1][2]; b = e[0][2] - e[2][0]; c = e[1][0] - e[0][1];
    end else if (e[0][0] > e[1][1] && e[0][0] > e[2][2]) begin
      br = BR_X; rad = one + e[0][0] - e[1][1] - e[2][2];
      a = e[2][1] - e[1][2]; b = e[0][1] + e[1][0]; c = e[0][2] + e[2][0];
    end else if (e[1][1] > e[2][2]) begin
      br = BR_Y; rad = one + e[1][1] - e[0][0] - e[2][2];
      a = e[0][2] - e[2][0]; b = e[0][1] + e[1][0]; c = e[1][2] + e[2][1];
    end else begin
      br = BR_Z; rad = one + e[2][2] - e[0][0] - e[1][1];
      a = e[1][0] - e[0][1]; b = e[0][2] + e[2][0]; c = e[1][2] + e[2][1];
    end
    root = (rad > 0) ? root_q30(rad) : 0;
    div = 2 * root;
    if (div == 0) begin
      o.qw = '0; o.qx = '0; o.qy = '0; o.qz = '0; o.deg = 1'b1;
      return o;
    end
    qd = sat_quat(longint'(root >> 1));
    qa = frac_div(a, div); qb = frac_div(b, div); qc = frac_div(c, div);
    k = 0;
    for (int i = 0; i < 4; i++) begin
      if (i == br) slot[i] = qd;
      else begin
        slot[i] = (k == 0) ? qa : (k == 1) ? qb : qc;
        k++;
      end
    end
    o.qw = slot[0]; o.qx = slot[1]; o.qy = slot[2]; o.qz = slot[3];
    o.deg = 1'b0;
    return o;
  endfunction

  // drive one pose and wait for its transaction
  task automatic send_pose(ned_pose_t p);
    int gap;
    @(negedge clk);
    if (!calm && $urandom_range(0, 99) < 12) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    north_in <= p.north; east_in <= p.east; down_in <= p.down;
    q_w_in <= p.qw; q_x_in <= p.qx; q_y_in <= p.qy; q_z_in <= p.qz;
    do @(posedge clk); while (!in_ready);
    enu_expected_q.push_back(enu_of_ned(p));
    poses_sent++;
  endtask

  // stop offering poses, then wait until every result has come back
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (enu_expected_q.size() == 0);
  endtask

  // receiver side: random stalls, calm stretches and requested long hold-offs
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (calm) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= 12);
    end
  end

  // compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    enu_pose_t want, got;
    if (!rst && out_valid && out_ready) begin
      got = '{east_out, north_out, up_out, q_w_out, q_x_out, q_y_out, q_z_out, degenerate};
      if (enu_expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction: %p", got);
      end else begin
        want = enu_expected_q.pop_front();
        poses_checked++;
        if (want.deg) degen_seen++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch on pose %0d\n  expected %p\n  actual   %p",
                     poses_checked, want, got);
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("watchdog expired with %0d results pending", enu_expected_q.size());
      $display("[ned_to_enu_pose_conversion_core] ERROR");
      $finish;
    end
  end

  function automatic ned_pose_t raw_pose();
    ned_pose_t p;
    p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return p;
  endfunction

  // random rotation, normalized in real arithmetic then quantized to q2.30
  function automatic ned_pose_t unit_pose();
    ned_pose_t p;
    real c[4];
    real n;
    p = raw_pose();
    n = 0.0;
    for (int i = 0; i < 4; i++) begin
      c[i] = real'($urandom_range(0, 2000000)) / 1.0e6 - 1.0;
      if ($urandom_range(0, 7) == 0) c[i] = 0.0;
      n = n + c[i] * c[i];
    end
    if (n < 1.0e-6) begin
      c[0] = 1.0; n = 1.0;
    end
    n = $sqrt(n);
    p.qw = $rtoi(c[0] / n * 1073741823.0);
    p.qx = $rtoi(c[1] / n * 1073741823.0);
    p.qy = $rtoi(c[2] / n * 1073741823.0);
    p.qz = $rtoi(c[3] / n * 1073741823.0);
    return p;
  endfunction

  task automatic test_position_extremes();
    logic signed [PW-1:0] vals[5];
    ned_pose_t p;
    vals = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh0, -32'sh1, 32'sh8000_0001};
    for (int i = 0; i < 5; i++) begin
      p = '{vals[i], vals[(i + 1) % 5], vals[i], 32'sh4000_0000, 0, 0, 0};
      send_pose(p);
    end
  endtask

  // axis and diagonal rotations for the trace-method branch choice plus non-unit corners
  task automatic test_attitude_branches();
    logic signed [QW-1:0] q[11][4];
    q = '{'{32'sh4000_0000, 0, 0, 0}, '{0, 32'sh4000_0000, 0, 0},
          '{0, 0, 32'sh4000_0000, 0}, '{0, 0, 0, 32'sh4000_0000},
          '{32'sh2d41_3ccc, 32'sh2d41_3ccc, 0, 0}, '{0, 0, 32'sh2d41_3ccc, -32'sh2d41_3ccc},
          '{-32'sh4000_0000, 0, 0, 0}, '{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff},
          '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000},
          '{0, 32'sh8000_0000, 32'sh7fff_ffff, 0}, '{0, 0, 0, 0}};
    for (int i = 0; i < 11; i++)
      send_pose('{32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, q[i][0], q[i][1], q[i][2], q[i][3]});
  endtask

  // large equal-magnitude components push the rotation matrix entries far outside the unit range
  task automatic test_degenerate();
    logic signed [QW-1:0] m[4];
    m = '{32'sh7fff_ffff, 32'sh6000_0000, 32'sh8000_0000, 32'sh5a82_7999};
    for (int i = 0; i < 4; i++) begin
      send_pose('{0, 0, 0, 0, m[i], m[i], -m[i]});
      send_pose('{0, 0, 0, m[i], m[i], m[i], m[i]});
    end
  endtask

  task automatic test_random_poses(int count);
    for (int i = 0; i < count; i++) begin
      calm = (i >= count / 3) && (i < count / 3 + 200);
      send_pose(($urandom_range(0, 99) < 75) ? unit_pose() : raw_pose());
    end
    calm = 1'b0;
  endtask

  // receiver holds off long enough for the pipeline to fill, then sender waits out the queue
  task automatic test_backpressure();
    hold_left = LONG_HOLD;
    for (int i = 0; i < 120; i++) send_pose(unit_pose());
    drain();
    for (int i = 0; i < 30; i++) send_pose(raw_pose());
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_position_extremes();
    test_attitude_branches();
    test_degenerate();
    test_random_poses(700);
    test_backpressure();
    test_random_poses(680);
    drain();
    repeat (100) @(posedge clk);
    $display("sent %0d poses (position extremes, all four branches, degenerate and non-unit",
             poses_sent);
    $display("attitudes, long output stall); checked %0d, %0d degenerate, %0d mismatches",
             poses_checked, degen_seen, mismatches);
    if (mismatches == 0 && enu_expected_q.size() == 0)
      $display("[ned_to_enu_pose_conversion_core] OK");
    else
      $display("[ned_to_enu_pose_conversion_core] ERROR");
    $finish;
  end

endmodule
